// ----- rtl/utf8sd_pkg.sv -----
// ============================================================================
// UTF-8 stream decoder package
// Shared widths, byte prefix codes and the result type of the decoder.
// ============================================================================
package utf8sd_pkg;

	// Field widths.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 20;
	localparam int unsigned PEND_W  = 2;
	localparam int unsigned TDATA_W = ((CP_W + 7) / 8) * 8;

	// Byte prefix codes, matched against the top bits of a byte.
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [5:0] LEAD4_TAG = 6'b111100;

	// Continuation counts loaded by the lead bytes.
	localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
	localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

	// One decoded result as it travels to the output register.
	typedef struct packed {
		logic            emit;
		logic            err;
		logic            done;
		logic [CP_W-1:0] cp;
	} res_t;

endpackage

// ----- rtl/utf8sd_decode.sv -----
// ============================================================================
// UTF-8 decode step
// Holds the pending count and the partial code point, and turns the byte in
// the input register into at most one result.
// ============================================================================
module utf8sd_decode (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic [utf8sd_pkg::BYTE_W-1:0]    byte_s1,
	input  logic                             last_s1,
	output utf8sd_pkg::res_t                 res
);

	logic [utf8sd_pkg::PEND_W-1:0] pend_q;
	logic [utf8sd_pkg::CP_W-1:0]   part_q;
	logic [utf8sd_pkg::PEND_W-1:0] pend_d;
	logic [utf8sd_pkg::CP_W-1:0]   part_d;
	logic [utf8sd_pkg::CP_W-1:0]   shifted;
	logic                          fail;

	assign shifted = {part_q[utf8sd_pkg::CP_W-7:0], byte_s1[5:0]};

	// Next state and result for the byte in the input register.
	always_comb begin
		pend_d   = pend_q;
		part_d   = part_q;
		fail     = 1'b0;
		res.emit = 1'b0;
		res.err  = 1'b0;
		res.done = last_s1;
		res.cp   = '0;
		if (pend_q == utf8sd_pkg::PEND_NONE) begin
			priority if (!byte_s1[7]) begin
				res.emit = 1'b1;
				res.cp   = utf8sd_pkg::CP_W'(byte_s1);
			end else if (byte_s1[7:6] == utf8sd_pkg::CONT_TAG) begin
				fail = 1'b1;
			end else if (byte_s1[7:5] == utf8sd_pkg::LEAD2_TAG) begin
				pend_d = utf8sd_pkg::PEND_ONE;
				part_d = utf8sd_pkg::CP_W'(byte_s1[4:0]);
				fail   = last_s1;
			end else if (byte_s1[7:4] == utf8sd_pkg::LEAD3_TAG) begin
				pend_d = utf8sd_pkg::PEND_TWO;
				part_d = utf8sd_pkg::CP_W'(byte_s1[3:0]);
				fail   = last_s1;
			end else if (byte_s1[7:2] == utf8sd_pkg::LEAD4_TAG) begin
				pend_d = utf8sd_pkg::PEND_THREE;
				part_d = utf8sd_pkg::CP_W'(byte_s1[1:0]);
				fail   = last_s1;
			end else begin
				fail = 1'b1;
			end
		end else if (byte_s1[7:6] != utf8sd_pkg::CONT_TAG) begin
			fail = 1'b1;
		end else begin
			pend_d = pend_q - utf8sd_pkg::PEND_ONE;
			part_d = shifted;
			if (pend_d == utf8sd_pkg::PEND_NONE) begin
				res.emit = 1'b1;
				res.cp   = shifted;
				part_d   = '0;
			end else begin
				fail = last_s1;
			end
		end
		// Any error drops the sequence and reports a zero code point.
		if (fail) begin
			pend_d   = utf8sd_pkg::PEND_NONE;
			part_d   = '0;
			res.emit = 1'b1;
			res.err  = 1'b1;
			res.cp   = '0;
		end
	end

	// Sequence state advances only when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= utf8sd_pkg::PEND_NONE;
			part_q <= '0;
		end else if (advance) begin
			pend_q <= pend_d;
			part_q <= part_d;
		end
	end

endmodule

// ----- rtl/utf8sd_out_reg.sv -----
// ============================================================================
// UTF-8 decoder result register
// Holds one result on the master side until the receiver takes it.
// ============================================================================
module utf8sd_out_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  utf8sd_pkg::res_t                    res,
	output logic                                room,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [utf8sd_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast
);

	logic                        valid_q;
	logic [utf8sd_pkg::CP_W-1:0] cp_q;
	logic                        err_q;
	logic                        done_q;

	// The slot is free when empty or emptied in this cycle.
	assign room = !valid_q || m_axis_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load && res.emit;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (room && load && res.emit) begin
			cp_q   <= res.cp;
			err_q  <= res.err;
			done_q <= res.done;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = utf8sd_pkg::TDATA_W'(cp_q);
	assign m_axis_tuser  = err_q;
	assign m_axis_tlast  = done_q;

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// ============================================================================
// UTF-8 stream decoder
// Decodes a byte stream of UTF-8 text into code points of up to 20 bits.
// ============================================================================
// Usage:
//   The slave side takes one byte per item in s_axis_tdata, with s_axis_tlast
//   marking the last byte of a string. The master side gives zero or one
//   item per byte: the code point in m_axis_tdata, an error flag in
//   m_axis_tuser and the end-of-string mark of the causing byte in
//   m_axis_tlast. Lead bytes of a sequence give no item; the byte that
//   completes it does. Stray or bad bytes and strings cut mid-sequence give
//   an error item with a zero code point and return the decoder to idle.
//   A byte is accepted into the input register, then passes through the
//   decode step into the result register. Throughput is one byte per cycle
//   while the receiver keeps taking results, set by the single decode step
//   between those two registers.
//   Reset clears both registers' valid flags and the sequence state.
//   When the receiver stalls, the result register holds its item and an empty
//   input register still takes one more byte before s_axis_tready drops.
// ============================================================================
module utf8_stream_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [utf8sd_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] in_byte
	input  logic                                s_axis_tlast,   // end_of_string
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [utf8sd_pkg::TDATA_W-1:0]      m_axis_tdata,   // [19:0] code_point, rest zero
	output logic                                m_axis_tuser,   // [0] error
	output logic                                m_axis_tlast    // string_done
);

	logic                          valid_s1;
	logic [utf8sd_pkg::BYTE_W-1:0] byte_s1;
	logic                          last_s1;
	logic                          room;
	logic                          advance;
	utf8sd_pkg::res_t              res;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	utf8sd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.res     (res)
	);

	utf8sd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance),
		.res           (res),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// An error item always carries a zero code point.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("error item with nonzero code point");

	// A held input byte must leave once the result slot opens.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && room) |=> (s_axis_tready || ($past(s_axis_tvalid) && $past(s_axis_tready))))
		else $error("input register stuck while result slot free");

	// An emitted result of a stalled slot is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> (!advance && !s_axis_tready) || !valid_s1)
		else $error("decode advanced into a full result slot");

endmodule
